### rtl/core/hsr_pkg.sv
package hsr_pkg;

    // fixed field widths of the record channels
    localparam int KEY_W = 48;
    localparam int PAY_W = 64;

    typedef struct packed {
        logic [KEY_W-1:0] record_key;
        logic [PAY_W-1:0] record_payload;
        logic             final_record;
    } t_in_rec;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [PAY_W-1:0] sorted_payload;
        logic             end_of_set;
        logic             records_dropped;
    } t_out_rec;

    // read port address selection
    typedef logic [2:0] t_rd_sel;
    localparam t_rd_sel RD_NONE     = 3'd0;
    localparam t_rd_sel RD_TOP      = 3'd1;
    localparam t_rd_sel RD_SORT     = 3'd2;
    localparam t_rd_sel RD_CHILD    = 3'd3;
    localparam t_rd_sel RD_EMIT0    = 3'd4;
    localparam t_rd_sel RD_EMIT_NXT = 3'd5;

    // write port selection
    typedef logic [2:0] t_wr_sel;
    localparam t_wr_sel WR_NONE  = 3'd0;
    localparam t_wr_sel WR_LOAD  = 3'd1;
    localparam t_wr_sel WR_ROOT  = 3'd2;
    localparam t_wr_sel WR_CHILD = 3'd3;
    localparam t_wr_sel WR_SWAP  = 3'd4;

    typedef struct packed {
        logic    take_in;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    build_init;
        logic    top_dec;
        logic    root_top;
        logic    emit_first;
        logic    emit_next;
        logic    out_load;
        logic    finish;
    } t_cmd;

    typedef struct packed {
        logic in_final;
        logic child_out;
        logic go_down;
        logic top_zero;
        logic last_zero;
        logic out_taken;
        logic out_end;
    } t_sts;

endpackage

### rtl/core/hsr_ctrl.sv
module hsr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hsr_pkg::t_sts i_sts,
    output hsr_pkg::t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_BINIT   = 4'd1;
    localparam logic [3:0] ST_BRD     = 4'd2;
    localparam logic [3:0] ST_BROOT   = 4'd3;
    localparam logic [3:0] ST_SRD     = 4'd4;
    localparam logic [3:0] ST_SCMP    = 4'd5;
    localparam logic [3:0] ST_SORT_RD = 4'd6;
    localparam logic [3:0] ST_SORT_SW = 4'd7;
    localparam logic [3:0] ST_EMIT0   = 4'd8;
    localparam logic [3:0] ST_ELOAD   = 4'd9;
    localparam logic [3:0] ST_EWAIT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_sort;
    logic       n_sort;
    logic       sift_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sort  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sort  <= n_sort;
        end
    end

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_sort    = r_sort;
        sift_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.take_in = 1'b1;
                o_cmd.wr_sel  = hsr_pkg::WR_LOAD;
                if (i_sts.in_final) begin
                    n_state = ST_BINIT;
                end
            end
            ST_BINIT: begin
                o_cmd.build_init = 1'b1;
                n_sort           = 1'b0;
                n_state          = ST_BRD;
            end
            ST_BRD: begin
                o_cmd.rd_sel = hsr_pkg::RD_TOP;
                n_state      = ST_BROOT;
            end
            ST_BROOT: begin
                o_cmd.root_top = 1'b1;
                n_state        = ST_SRD;
            end
            ST_SRD: begin
                if (i_sts.child_out) begin
                    o_cmd.wr_sel = hsr_pkg::WR_ROOT;
                    sift_done    = 1'b1;
                end else begin
                    o_cmd.rd_sel = hsr_pkg::RD_CHILD;
                    n_state      = ST_SCMP;
                end
            end
            ST_SCMP: begin
                if (i_sts.go_down) begin
                    o_cmd.wr_sel = hsr_pkg::WR_CHILD;
                    n_state      = ST_SRD;
                end else begin
                    o_cmd.wr_sel = hsr_pkg::WR_ROOT;
                    sift_done    = 1'b1;
                end
            end
            ST_SORT_RD: begin
                o_cmd.rd_sel = hsr_pkg::RD_SORT;
                n_state      = ST_SORT_SW;
            end
            ST_SORT_SW: begin
                o_cmd.wr_sel = hsr_pkg::WR_SWAP;
                n_sort       = 1'b1;
                n_state      = ST_SRD;
            end
            ST_EMIT0: begin
                o_cmd.emit_first = 1'b1;
                o_cmd.rd_sel     = hsr_pkg::RD_EMIT0;
                n_state          = ST_ELOAD;
            end
            ST_ELOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_EWAIT;
            end
            ST_EWAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.out_end) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        o_cmd.rd_sel    = hsr_pkg::RD_EMIT_NXT;
                        n_state         = ST_ELOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // after a sift: next build node, next extraction, or emit
        if (sift_done) begin
            if (!r_sort && !i_sts.top_zero) begin
                o_cmd.top_dec = 1'b1;
                n_state       = ST_BRD;
            end else if (i_sts.last_zero) begin
                n_state = ST_EMIT0;
            end else begin
                n_state = ST_SORT_RD;
            end
        end
    end

endmodule

### rtl/core/hsr_dpath.sv
module hsr_dpath #(
    parameter int MAX_RECORDS  = 64,
    parameter int KEY_BYTES    = 6,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsr_pkg::t_cmd     i_cmd,
    output hsr_pkg::t_sts     o_sts,
    input  logic              i_in_valid,
    input  hsr_pkg::t_in_rec  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hsr_pkg::t_out_rec o_out_data
);

    localparam int AW     = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int KW_RAW = KEY_BYTES * 8;
    localparam int KW     = (KW_RAW < hsr_pkg::KEY_W) ? KW_RAW : hsr_pkg::KEY_W;
    localparam int PW     = PAYLOAD_BITS;

    logic [KW-1:0] mem_key [MAX_RECORDS];
    logic [PW-1:0] mem_pay [MAX_RECORDS];

    logic [CNT_W-1:0]  r_count;
    logic              r_overflow;
    logic              r_out_valid;
    hsr_pkg::t_out_rec r_out;
    logic [AW-1:0]     r_top;
    logic [AW-1:0]     r_last;
    logic [AW-1:0]     r_node;
    logic [AW-1:0]     r_emit;
    logic [KW-1:0]     r_root_key;
    logic [PW-1:0]     r_root_pay;
    logic [KW-1:0]     r_rd_key_a;
    logic [KW-1:0]     r_rd_key_b;
    logic [PW-1:0]     r_rd_pay_a;
    logic [PW-1:0]     r_rd_pay_b;

    logic          room;
    logic [AW-1:0] last_idx;
    logic [AW:0]   child;
    logic [AW-1:0] child_lo;
    logic          has_right;
    logic          pick_b;
    logic [KW-1:0] sel_key;
    logic [PW-1:0] sel_pay;
    logic [AW-1:0] sel_idx;
    logic          rd_en;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_key;
    logic [PW-1:0] wr_pay;
    logic          out_xfer;

    assign room      = r_count < CNT_W'(MAX_RECORDS);
    assign last_idx  = AW'(r_count - 1'b1);
    assign child     = {r_node, 1'b1};
    assign child_lo  = child[AW-1:0];
    assign has_right = child < {1'b0, r_last};
    assign pick_b    = has_right && (r_rd_key_a < r_rd_key_b);
    assign sel_key   = pick_b ? r_rd_key_b : r_rd_key_a;
    assign sel_pay   = pick_b ? r_rd_pay_b : r_rd_pay_a;
    assign sel_idx   = child_lo + AW'(pick_b);
    assign out_xfer  = r_out_valid && i_out_ready;

    always_comb begin
        rd_en     = 1'b1;
        rd_addr_a = r_top;
        rd_addr_b = r_last;
        case (i_cmd.rd_sel)
            hsr_pkg::RD_TOP: begin
                rd_addr_a = r_top;
            end
            hsr_pkg::RD_SORT: begin
                rd_addr_a = '0;
                rd_addr_b = r_last;
            end
            hsr_pkg::RD_CHILD: begin
                rd_addr_a = child_lo;
                rd_addr_b = child_lo + 1'b1;
            end
            hsr_pkg::RD_EMIT0: begin
                rd_addr_a = '0;
            end
            hsr_pkg::RD_EMIT_NXT: begin
                rd_addr_a = r_emit + 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_key  = r_root_key;
        wr_pay  = r_root_pay;
        case (i_cmd.wr_sel)
            hsr_pkg::WR_LOAD: begin
                wr_en   = i_in_valid && room;
                wr_addr = r_count[AW-1:0];
                wr_key  = KW'(i_in_data.record_key);
                wr_pay  = PW'(i_in_data.record_payload);
            end
            hsr_pkg::WR_ROOT: begin
                wr_en = 1'b1;
            end
            hsr_pkg::WR_CHILD: begin
                wr_en  = 1'b1;
                wr_key = sel_key;
                wr_pay = sel_pay;
            end
            hsr_pkg::WR_SWAP: begin
                wr_en   = 1'b1;
                wr_addr = r_last;
                wr_key  = r_rd_key_a;
                wr_pay  = r_rd_pay_a;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // record store, one write and two registered reads a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr] <= wr_key;
            mem_pay[wr_addr] <= wr_pay;
        end
        if (rd_en) begin
            r_rd_key_a <= mem_key[rd_addr_a];
            r_rd_pay_a <= mem_pay[rd_addr_a];
            r_rd_key_b <= mem_key[rd_addr_b];
            r_rd_pay_b <= mem_pay[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_sel == hsr_pkg::WR_LOAD && i_in_valid) begin
                if (room) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_count    <= '0;
                r_overflow <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_top  <= AW'(r_count >> 1);
            r_last <= last_idx;
        end
        if (i_cmd.top_dec) begin
            r_top <= r_top - 1'b1;
        end
        if (i_cmd.root_top) begin
            r_root_key <= r_rd_key_a;
            r_root_pay <= r_rd_pay_a;
            r_node     <= r_top;
        end
        if (i_cmd.wr_sel == hsr_pkg::WR_CHILD) begin
            r_node <= sel_idx;
        end
        // old entry 0 goes to the tail, old tail becomes the sifted root
        if (i_cmd.wr_sel == hsr_pkg::WR_SWAP) begin
            r_root_key <= r_rd_key_b;
            r_root_pay <= r_rd_pay_b;
            r_node     <= '0;
            r_last     <= r_last - 1'b1;
        end
        if (i_cmd.emit_first) begin
            r_emit <= '0;
        end
        if (i_cmd.emit_next) begin
            r_emit <= r_emit + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.sorted_key      <= hsr_pkg::KEY_W'(r_rd_key_a);
            r_out.sorted_payload  <= hsr_pkg::PAY_W'(r_rd_pay_a);
            r_out.end_of_set      <= (r_emit == last_idx);
            r_out.records_dropped <= r_overflow;
        end
    end

    assign o_sts.in_final  = i_in_valid && i_in_data.final_record;
    assign o_sts.child_out = child > {1'b0, r_last};
    assign o_sts.go_down   = r_root_key < sel_key;
    assign o_sts.top_zero  = (r_top == '0);
    assign o_sts.last_zero = (r_last == '0);
    assign o_sts.out_taken = out_xfer;
    assign o_sts.out_end   = r_out.end_of_set;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/core/heap_sort_records_top.sv
// heap sort of keyed records: records come in one per transfer and are stored
// in a single-port-write, dual-read memory until a transfer marked final_record
// arrives; the set (at most MAX_RECORDS, later ones are dropped and flagged) is
// then heap-sorted in place by ascending unsigned key and streamed out in
// order, end_of_set on the last one. loading accepts one record per cycle
// with o_in_ready high only while idle. sorting is a sift-down loop on the
// record memory, one heap level at a time (read both children, compare, write
// back), for each build sift and each extraction. emitting presents a record
// only after the previous one has been taken.
module heap_sort_records_top #(
    parameter int MAX_RECORDS  = 64,
    parameter int KEY_BYTES    = 6,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // record input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hsr_pkg::t_in_rec  i_in_data,
    // sorted output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hsr_pkg::t_out_rec o_out_data
);

    hsr_pkg::t_cmd cmd;
    hsr_pkg::t_sts sts;

    // sequencer: load, heap build, extraction, emit
    hsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // record memory, sift registers and output register
    hsr_dpath #(
        .MAX_RECORDS  (MAX_RECORDS),
        .KEY_BYTES    (KEY_BYTES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // input transfers only while idle
    assign o_in_ready = cmd.take_in;

endmodule

### rtl/core/hsr_checker.sv
module hsr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input hsr_pkg::t_in_rec  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input hsr_pkg::t_out_rec o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // no input transfer while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready during emit");

    // final record starts sorting, input closes
    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.final_record |=> !o_in_ready && !o_out_valid)
        else $error("input still open after final record");

    // last result of a set returns the block to idle
    a_end_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.end_of_set |=> o_in_ready && !o_out_valid)
        else $error("block not idle after end of set");

endmodule

bind heap_sort_records_top hsr_checker u_hsr_checker (.*);

### bench/tb_heap_sort_records_top.sv
module tb_heap_sort_records_top;

    localparam int KEY_W = hsr_pkg::KEY_W;
    localparam int PAY_W = hsr_pkg::PAY_W;

    // store depth of the instance; records past this are dropped and flagged
    localparam int STORE_DEPTH = 64;
    // cycles without any transfer before the run is declared hung; this leaves
    // wide margin over the quiet stretch of a full 64-record sort
    localparam int QUIET_LIMIT = 12000;
    // cycles to keep watching after the last expected record has come out
    localparam int DRAIN_CYCLES = 200;
    // random part stops once this many records have been sent
    localparam int RANDOM_RECORDS = 236;
    // from this many random records on, neither side idles any more
    localparam int CALM_FROM = 206;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    hsr_pkg::t_in_rec   in_data = '0;
    logic               out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    hsr_pkg::t_out_rec  o_out_data;

    heap_sort_records_top #(
        .MAX_RECORDS  (STORE_DEPTH),
        .KEY_BYTES    (6),
        .PAYLOAD_BITS (64)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state: records held since the last set closed
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] held_key     [STORE_DEPTH];
    logic [PAY_W-1:0] held_payload [STORE_DEPTH];
    int               held_count = 0;
    bit               held_overflow = 1'b0;

    // sorted records still owed by the block, oldest first
    hsr_pkg::t_out_rec sorted_due [$];

    int mismatches = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    int ready_hold = 0;
    hsr_pkg::t_out_rec due_head;

    function automatic void swap_held(input int a, input int b);
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] p;
        k = held_key[a];
        p = held_payload[a];
        held_key[a] = held_key[b];
        held_payload[a] = held_payload[b];
        held_key[b] = k;
        held_payload[b] = p;
    endfunction

    // push the entry at top down the max-heap spanning top..bottom; the
    // larger child is only looked at when both children lie in range
    function automatic void sift_held(input int top, input int bottom);
        int node;
        int child;
        logic [KEY_W-1:0] root_key;
        node = top;
        child = 2 * top + 1;
        root_key = held_key[top];
        if (child < bottom && held_key[child] < held_key[child + 1])
            child++;
        while (child <= bottom && root_key < held_key[child]) begin
            swap_held(node, child);
            node = child;
            child = 2 * child + 1;
            if (child < bottom && held_key[child] < held_key[child + 1])
                child++;
        end
    endfunction

    // build pass starts at index n/2, then extract max to the end
    function automatic void heap_sort_held(input int n);
        int i;
        int bottom;
        i = n / 2 + 1;
        while (i > 0) begin
            i--;
            sift_held(i, n - 1);
        end
        bottom = n - 1;
        while (bottom > 0) begin
            swap_held(0, bottom);
            bottom--;
            sift_held(0, bottom);
        end
    endfunction

    // account for one accepted record; a final mark sorts and releases the set
    function automatic void take_record(input hsr_pkg::t_in_rec rec, input bit owe_results);
        hsr_pkg::t_out_rec res;
        int n;
        if (held_count < STORE_DEPTH) begin
            held_key[held_count] = rec.record_key;
            held_payload[held_count] = rec.record_payload;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (rec.final_record) begin
            n = held_count;
            heap_sort_held(n);
            for (int k = 0; k < n; k++) begin
                res.sorted_key = held_key[k];
                res.sorted_payload = held_payload[k];
                res.end_of_set = (k == n - 1);
                res.records_dropped = held_overflow;
                if (owe_results)
                    sorted_due.push_back(res);
            end
            held_count = 0;
            held_overflow = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                   input logic [PAY_W-1:0] want);
        mismatches++;
        $display("mismatch on record %0d, %s: got %h, want %h",
                 results_seen, what, got, want);
    endtask

    // one record transfer; an idle burst may come first, valid then holds
    // with fixed payload until the block takes it
    task automatic send_record(input hsr_pkg::t_in_rec rec);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= rec;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // sink side: ready drops in random bursts until the calm tail
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(1, 7) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // compare each output transfer against the oldest owed record
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (sorted_due.size() == 0) begin
                report_mismatch("record with none owed", PAY_W'(o_out_data.sorted_key), '0);
            end else begin
                due_head = sorted_due.pop_front();
                if (o_out_data.sorted_key !== due_head.sorted_key)
                    report_mismatch("sorted_key", PAY_W'(o_out_data.sorted_key),
                                    PAY_W'(due_head.sorted_key));
                if (o_out_data.sorted_payload !== due_head.sorted_payload)
                    report_mismatch("sorted_payload", o_out_data.sorted_payload,
                                    due_head.sorted_payload);
                if (o_out_data.end_of_set !== due_head.end_of_set)
                    report_mismatch("end_of_set", PAY_W'(o_out_data.end_of_set),
                                    PAY_W'(due_head.end_of_set));
                if (o_out_data.records_dropped !== due_head.records_dropped)
                    report_mismatch("records_dropped", PAY_W'(o_out_data.records_dropped),
                                    PAY_W'(due_head.records_dropped));
            end
            results_seen++;
        end
    end

    // watchdog: too long with no transfer on either channel means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // directed records; single-record sets carry their result inline
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic             closes_set;
        logic             typed;
        logic [KEY_W-1:0] want_key;
        logic [PAY_W-1:0] want_payload;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 24;

    t_stim_row stim_rows [DIRECTED_ROWS] = '{
        // lone records at the extremes come straight back
        '{48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
          48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
        '{48'h0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1, 1'b1,
          48'h0000_0000_0000, 64'h0000_0000_0000_0000},
        '{48'hAAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 1'b1,
          48'hAAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
        '{48'h5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1,
          48'h5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
        // most significant byte decides before the lower ones
        '{48'h00FF_FFFF_FFFF, 64'd1, 1'b0, 1'b0, '0, '0},
        '{48'h0100_0000_0000, 64'd2, 1'b0, 1'b0, '0, '0},
        '{48'hFFFF_FFFF_FFFE, 64'd3, 1'b0, 1'b0, '0, '0},
        '{48'h0000_0000_0001, 64'd4, 1'b0, 1'b0, '0, '0},
        '{48'h8000_0000_0000, 64'd5, 1'b1, 1'b0, '0, '0},
        // equal keys: order follows the heap, not arrival
        '{48'd7, 64'd10, 1'b0, 1'b0, '0, '0},
        '{48'd7, 64'd11, 1'b0, 1'b0, '0, '0},
        '{48'd3, 64'd12, 1'b0, 1'b0, '0, '0},
        '{48'd7, 64'd13, 1'b0, 1'b0, '0, '0},
        '{48'd3, 64'd14, 1'b0, 1'b0, '0, '0},
        '{48'd7, 64'd15, 1'b1, 1'b0, '0, '0},
        // reverse order input
        '{48'd5, 64'd20, 1'b0, 1'b0, '0, '0},
        '{48'd4, 64'd21, 1'b0, 1'b0, '0, '0},
        '{48'd3, 64'd22, 1'b0, 1'b0, '0, '0},
        '{48'd2, 64'd23, 1'b0, 1'b0, '0, '0},
        '{48'd1, 64'd24, 1'b1, 1'b0, '0, '0},
        // already sorted input
        '{48'd1, 64'd30, 1'b0, 1'b0, '0, '0},
        '{48'd2, 64'd31, 1'b0, 1'b0, '0, '0},
        '{48'd3, 64'd32, 1'b0, 1'b0, '0, '0},
        '{48'd4, 64'd33, 1'b1, 1'b0, '0, '0}
    };

    initial begin
        hsr_pkg::t_in_rec  rec;
        hsr_pkg::t_out_rec want;
        int                sent;
        int                set_no;
        int                set_size;
        int                key_style;
        logic [KEY_W-9:0]  key_prefix;

        // synchronous reset, released on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            rec.record_key = stim_rows[r].key;
            rec.record_payload = stim_rows[r].payload;
            rec.final_record = stim_rows[r].closes_set;
            send_record(rec);
            take_record(rec, !stim_rows[r].typed);
            if (stim_rows[r].typed) begin
                want.sorted_key = stim_rows[r].want_key;
                want.sorted_payload = stim_rows[r].want_payload;
                want.end_of_set = 1'b1;
                want.records_dropped = 1'b0;
                sorted_due.push_back(want);
            end
        end

        // random sets: an exactly full set, one whose final record is the
        // first to be dropped, and one that drops a plain record before the
        // dropped final come first, so the calm tail is made of short sets
        sent = 0;
        set_no = 0;
        while (sent < RANDOM_RECORDS) begin
            case (set_no)
                0: begin
                    set_size = STORE_DEPTH;
                end
                1: begin
                    set_size = STORE_DEPTH + 1;
                end
                2: begin
                    set_size = STORE_DEPTH + 2;
                end
                default: begin
                    set_size = $urandom_range(1, 12);
                end
            endcase
            calm = (sent >= CALM_FROM);
            // key flavor per set: wide random, few distinct values (many
            // ties), or shared upper bytes so the low byte decides
            key_style = $urandom_range(0, 2);
            key_prefix = 40'({$urandom, $urandom});
            for (int k = 0; k < set_size; k++) begin
                case (key_style)
                    0: begin
                        rec.record_key = {16'($urandom), $urandom};
                    end
                    1: begin
                        rec.record_key = KEY_W'($urandom_range(0, 7));
                    end
                    default: begin
                        rec.record_key = {key_prefix, 8'($urandom_range(0, 15) << 4)};
                        rec.record_key[3:0] = 4'($urandom);
                    end
                endcase
                rec.record_payload = {$urandom, $urandom};
                rec.final_record = (k == set_size - 1);
                send_record(rec);
                take_record(rec, 1'b1);
            end
            sent += set_size;
            set_no++;
        end

        @(negedge i_clk);
        in_valid <= 1'b0;

        // every owed record must come out; the watchdog covers a hang
        while (sorted_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
